/* hdl/owb_pkg.sv */
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types, codes and helpers for the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owb_pkg;

    // Command codes carried with each tick
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SHORT = 2'd0;
    localparam logic [1:0] CFG_LONG  = 2'd1;
    localparam logic [1:0] CFG_RESET = 2'd2;

    // Field widths
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 10;
    localparam int ShortW   = 8;
    localparam int LongW    = 8;
    localparam int RstW     = 10;
    localparam int CntW     = 10;
    localparam int ByteW    = 8;
    localparam int BitCntW  = 3;

    // Interval register reset values
    localparam logic [ShortW-1:0] SHORT_RST = 8'd7;
    localparam logic [LongW-1:0]  LONG_RST  = 8'd70;
    localparam logic [RstW-1:0]   RESET_RST = 10'd500;

    localparam logic [BitCntW-1:0] LAST_BIT = 3'd7;
    localparam logic [ByteW-1:0]   MSB_MASK = 8'h80;

    // Bus phase, one-hot
    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_RST_LOW  = 9'b000000010,
        PH_RST_WAIT = 9'b000000100,
        PH_RST_POST = 9'b000001000,
        PH_W_LOW    = 9'b000010000,
        PH_W_HIGH   = 9'b000100000,
        PH_R_LOW    = 9'b001000000,
        PH_R_WAIT   = 9'b010000000,
        PH_R_POST   = 9'b100000000
    } phase_t;

    // Interval length: a zero setting counts as one tick
    function automatic logic [CntW-1:0] ivl_len(input logic [CntW-1:0] len);
        return (len == '0) ? CntW'(1) : len;
    endfunction

endpackage

/* hdl/owb_if.sv */
// ----------------------------------------------------------------------------
// owb_cmd_if / owb_res_if
// Valid/ready channels for tick commands and per-tick results.
// ----------------------------------------------------------------------------
interface owb_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] write_data;
    logic       line_level;

    modport source  (output valid, operation, write_data, line_level, input ready);
    modport sink    (input valid, operation, write_data, line_level, output ready);
    modport monitor (input valid, ready, operation, write_data, line_level);
endinterface

interface owb_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic       bus_fault;
    logic [7:0] read_data;

    modport source  (output valid, drive_low, busy_res, done_res, presence, bus_fault,
                     read_data, input ready);
    modport sink    (input valid, drive_low, busy_res, done_res, presence, bus_fault,
                     read_data, output ready);
    modport monitor (input valid, ready, drive_low, busy_res, done_res, presence,
                     bus_fault, read_data);
endinterface

/* hdl/onewire_bus_master.sv */
// ----------------------------------------------------------------------------
// onewire_bus_master
// 1-Wire bus master stepped by one microsecond tick per transfer.
// ----------------------------------------------------------------------------
// Each cmd transfer is one timebase tick carrying an optional command and the
// sampled line level; it yields exactly one rsp transfer describing that tick,
// registered in the result register. A new tick is taken every clock as long as the
// rsp side keeps up: the single result register is the only buffer, so cmd
// ready follows rsp ready when a result is pending. Commands that arrive while
// a reset, write or read is running are ignored. Interval registers (in ticks)
// are sampled when each interval begins; a setting of zero counts as one tick.
// ----------------------------------------------------------------------------
module onewire_bus_master
    import owb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    owb_cmd_if.sink             cmd,
    owb_res_if.source           rsp
);

    // Configuration
    logic [ShortW-1:0] short_reg;
    logic [LongW-1:0]  long_reg;
    logic [RstW-1:0]   rstt_reg;

    // Bus state
    phase_t             phase_reg,  phase_next;
    logic [CntW-1:0]    cnt_reg,    cnt_next;
    logic [BitCntW-1:0] bits_reg,   bits_next;
    logic [ByteW-1:0]   shift_reg,  shift_next;
    logic               pres_reg,   pres_next;
    logic               fault_reg,  fault_next;
    logic [ByteW-1:0]   hold_reg,   hold_next;

    // Result register
    logic               rvalid_reg;
    logic               drive_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               drive_next;
    logic               done_next;

    logic               cmd_fire;
    logic [CntW-1:0]    short_len;
    logic [CntW-1:0]    long_len;
    logic [CntW-1:0]    rstt_len;

    assign cmd.ready = !rvalid_reg || rsp.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign short_len = ivl_len(CntW'(short_reg));
    assign long_len  = ivl_len(CntW'(long_reg));
    assign rstt_len  = ivl_len(CntW'(rstt_reg));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg <= SHORT_RST;
            long_reg  <= LONG_RST;
            rstt_reg  <= RESET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SHORT: short_reg <= cfg_data[ShortW-1:0];
                CFG_LONG:  long_reg  <= cfg_data[LongW-1:0];
                CFG_RESET: rstt_reg  <= cfg_data[RstW-1:0];
                default:   ;
            endcase
        end
    end

    // One tick of the bus sequencer
    always_comb
    begin
        logic run;
        phase_t ph;
        logic last;

        run        = 1'b1;
        ph         = phase_reg;
        last       = 1'b0;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        pres_next  = pres_reg;
        fault_next = fault_reg;
        hold_next  = hold_reg;
        drive_next = 1'b0;
        done_next  = 1'b0;

        // Idle: start a command, its first interval begins on this tick
        case (phase_reg)
            PH_RST_LOW, PH_RST_WAIT, PH_RST_POST, PH_W_LOW, PH_W_HIGH,
            PH_R_LOW, PH_R_WAIT, PH_R_POST: run = 1'b1;
            default:
            begin
                ph  = PH_IDLE;
                run = 1'b0;
                case (cmd.operation)
                    OP_RESET:
                    begin
                        pres_next = 1'b0;
                        if (!cmd.line_level)
                        begin
                            // line already held low: bus fault, finish now
                            fault_next = 1'b1;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            fault_next = 1'b0;
                            ph         = PH_RST_LOW;
                            cnt_next   = rstt_len;
                            run        = 1'b1;
                        end
                    end
                    OP_WRITE:
                    begin
                        shift_next = cmd.write_data;
                        bits_next  = '0;
                        ph         = PH_W_LOW;
                        cnt_next   = cmd.write_data[0] ? short_len : long_len;
                        run        = 1'b1;
                    end
                    OP_READ:
                    begin
                        shift_next = '0;
                        bits_next  = '0;
                        ph         = PH_R_LOW;
                        cnt_next   = short_len;
                        run        = 1'b1;
                    end
                    default: ;
                endcase
            end
        endcase

        // Spend one tick in the current interval
        if (run)
        begin
            drive_next = (ph == PH_RST_LOW) || (ph == PH_W_LOW) || (ph == PH_R_LOW);
            last       = (cnt_next <= CntW'(1));
            cnt_next   = last ? '0 : cnt_next - CntW'(1);
            if (last)
            begin
                case (ph)
                    PH_RST_LOW:
                    begin
                        ph       = PH_RST_WAIT;
                        cnt_next = long_len;
                    end
                    PH_RST_WAIT:
                    begin
                        pres_next = !cmd.line_level;
                        ph        = PH_RST_POST;
                        cnt_next  = rstt_len;
                    end
                    PH_RST_POST:
                    begin
                        ph        = PH_IDLE;
                        done_next = 1'b1;
                    end
                    PH_W_LOW:
                    begin
                        ph       = PH_W_HIGH;
                        cnt_next = shift_next[0] ? long_len : short_len;
                    end
                    PH_W_HIGH:
                    begin
                        shift_next = {1'b0, shift_next[ByteW-1:1]};
                        if (bits_next == LAST_BIT)
                        begin
                            bits_next = '0;
                            ph        = PH_IDLE;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            bits_next = bits_next + BitCntW'(1);
                            ph        = PH_W_LOW;
                            cnt_next  = shift_next[0] ? short_len : long_len;
                        end
                    end
                    PH_R_LOW:
                    begin
                        ph       = PH_R_WAIT;
                        cnt_next = short_len;
                    end
                    PH_R_WAIT:
                    begin
                        shift_next = {1'b0, shift_next[ByteW-1:1]}
                                   | (cmd.line_level ? MSB_MASK : '0);
                        ph         = PH_R_POST;
                        cnt_next   = long_len;
                    end
                    default:
                    begin
                        // end of read slot
                        if (bits_next == LAST_BIT)
                        begin
                            bits_next = '0;
                            hold_next = shift_next;
                            ph        = PH_IDLE;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            bits_next = bits_next + BitCntW'(1);
                            ph        = PH_R_LOW;
                            cnt_next  = short_len;
                        end
                    end
                endcase
            end
        end
        phase_next = ph;
    end

    // State update on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            bits_reg  <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b0;
            fault_reg <= 1'b0;
            hold_reg  <= '0;
        end
        else if (cmd_fire)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
            fault_reg <= fault_next;
            hold_reg  <= hold_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rvalid_reg <= 1'b0;
        else if (cmd_fire)
            rvalid_reg <= 1'b1;
        else if (rsp.ready)
            rvalid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            drive_reg <= drive_next;
            busy_reg  <= (phase_next != PH_IDLE);
            done_reg  <= done_next;
        end
    end

    assign rsp.valid     = rvalid_reg;
    assign rsp.drive_low = drive_reg;
    assign rsp.busy_res  = busy_reg;
    assign rsp.done_res  = done_reg;
    assign rsp.presence  = pres_reg;
    assign rsp.bus_fault = fault_reg;
    assign rsp.read_data = hold_reg;

endmodule

/* hdl/owb_checker.sv */
// ----------------------------------------------------------------------------
// owb_checker
// Port-level checks for the 1-Wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
module owb_checker
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_ready,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  logic drive_low,
    input  logic busy_res,
    input  logic done_res,
    input  logic presence,
    input  logic bus_fault
);

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // With no result pending a tick is always taken
    a_cmd_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> cmd_ready)
        else $error("tick refused with empty result register");

    // The completing tick is never also busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(done_res && busy_res))
        else $error("done and busy together");

    // Pulling the line low always leaves the command running
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && drive_low |-> busy_res)
        else $error("line driven on a completing or idle tick");

    // A faulted reset never reports presence
    a_fault_pres: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && bus_fault |-> !presence)
        else $error("presence reported with bus fault");

endmodule

bind onewire_bus_master owb_checker u_owb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .drive_low (rsp.drive_low),
    .busy_res  (rsp.busy_res),
    .done_res  (rsp.done_res),
    .presence  (rsp.presence),
    .bus_fault (rsp.bus_fault)
);
